[hw/rtl/cv3_pkg.sv]
// ----------------------------------------------------------------------------
// cv3_pkg
// Shared types and constants of the 3x3 convolution block: field widths,
// configuration register indexes, result codes and the structs passed
// between the line-buffer front end, the multiply-add unit and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package cv3_pkg;

  // fixed widths of the ports and of the configuration registers
  localparam int unsigned PIX_IN_W  = 16;
  localparam int unsigned FILT_W    = 36;
  localparam int unsigned ROW_W     = 16;
  localparam int unsigned OUT_COL_W = 12;
  localparam int unsigned CFG_W     = 48;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned KREG_W    = 48;
  localparam int unsigned WREG_W    = 13;
  localparam int unsigned HREG_W    = 16;

  // results one item can cause at most
  localparam int unsigned NRES   = 4;
  localparam int unsigned NRES_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_KTOP   = 3'd2,
    REG_KMID   = 3'd3,
    REG_KBOT   = 3'd4
  } cfg_reg_e;

  // result slots of one item, in delivery order
  localparam int unsigned RES_UP_MID    = 0;  // row above, previous column
  localparam int unsigned RES_UP_EDGE   = 1;  // row above, right border
  localparam int unsigned RES_LAST_MID  = 2;  // last row, previous column
  localparam int unsigned RES_LAST_EDGE = 3;  // last row, right border

  // work handed from the window stage to the multiply-add unit
  typedef struct packed {
    logic [NRES-1:0]      mask;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
  } job_t;

  // one finished result
  typedef struct packed {
    logic signed [FILT_W-1:0] filtered;
    logic [ROW_W-1:0]         out_row;
    logic [OUT_COL_W-1:0]     out_col;
    logic                     frame_done;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/cv3_pix_if.sv]
// ----------------------------------------------------------------------------
// cv3_pix_if
// Valid/ready channel that carries one input pixel per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface cv3_pix_if;
  logic                          valid;
  logic                          ready;
  logic [cv3_pkg::PIX_IN_W-1:0]  pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

[hw/rtl/cv3_res_if.sv]
// ----------------------------------------------------------------------------
// cv3_res_if
// Valid/ready channel that carries one filtered result per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface cv3_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [cv3_pkg::FILT_W-1:0]   filtered;
  logic [cv3_pkg::ROW_W-1:0]           out_row;
  logic [cv3_pkg::OUT_COL_W-1:0]       out_col;
  logic                                frame_done;

  modport source (output valid, output filtered, output out_row, output out_col,
                  output frame_done, input ready);
  modport sink   (input valid, input filtered, input out_row, input out_col,
                  input frame_done, output ready);
endinterface

`default_nettype wire

[hw/rtl/cv3_ram.sv]
// ----------------------------------------------------------------------------
// cv3_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. A read of the address being written returns the
// old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module cv3_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/cv3_front.sv]
// ----------------------------------------------------------------------------
// cv3_front
// Raster counters, the line-buffer RAM (older and newer row packed in one
// word), read-modify-write of the line buffer with forwarding, and the 3x3
// window register. Hands a job with its result mask to the multiply-add unit.
// ----------------------------------------------------------------------------
`default_nettype none

module cv3_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             accept_i,
  input  wire logic [cv3_pkg::PIX_IN_W-1:0]     pixel_i,
  input  wire logic                             restart_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]     wlast_i,
  input  wire logic [cv3_pkg::ROW_W-1:0]        hlast_i,
  output      logic                             busy_o,
  output      logic [cv3_pkg::NRES_W-1:0]       nres_o,
  output      logic                             job_load_o,
  output      cv3_pkg::job_t                    job_o,
  output      logic [2:0][2:0][PIXEL_BITS-1:0]  win_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned PB    = PIXEL_BITS;

  // raster position of the next item
  logic [cv3_pkg::ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0]          col_q, col_d;
  logic                      last_row, last_col, row_ge1, col_ge1;
  logic [cv3_pkg::NRES-1:0]  mask0;
  logic [PB-1:0]             pix0;

  // hold-off counter for items with several results
  logic [1:0] blk_q, blk_d;

  // line buffer access
  logic [2*PB-1:0] rd_raw, rd_word, wr_word;
  logic            fwd_q;
  logic [2*PB-1:0] fwd_data_q;
  logic [PB-1:0]   rd_older, rd_newer;

  // stage one: line buffer data returns
  logic                s1_valid_q;
  logic [PB-1:0]       s1_pix_q;
  logic [COL_W-1:0]    s1_col_q;
  logic                s1_rzero_q, s1_rge2_q;
  cv3_pkg::job_t       s1_job_q;
  logic [2:0][PB-1:0]  newv;

  logic [2:0][2:0][PB-1:0] win_q;

  // position flags and result mask of the offered item
  always_comb begin
    pix0     = PB'(pixel_i);
    last_row = (row_q == hlast_i);
    last_col = (col_q == wlast_i);
    row_ge1  = (row_q != '0);
    col_ge1  = (col_q != '0);
    mask0                         = '0;
    mask0[cv3_pkg::RES_UP_MID]    = row_ge1 && col_ge1;
    mask0[cv3_pkg::RES_UP_EDGE]   = row_ge1 && last_col;
    mask0[cv3_pkg::RES_LAST_MID]  = last_row && col_ge1;
    mask0[cv3_pkg::RES_LAST_EDGE] = last_row && last_col;
    nres_o = cv3_pkg::NRES_W'(mask0[0]) + cv3_pkg::NRES_W'(mask0[1])
           + cv3_pkg::NRES_W'(mask0[2]) + cv3_pkg::NRES_W'(mask0[3]);
  end

  // counter advance
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (restart_i) begin
      row_d = '0;
      col_d = '0;
    end else if (accept_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 16'd1;
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  // hold-off: an item with k results keeps the input closed until the counter runs out
  always_comb begin
    blk_d = blk_q;
    if (accept_i) begin
      blk_d = (nres_o >= 3'd2) ? 2'(nres_o - 3'd1) : 2'd0;
    end else if (blk_q != 2'd0) begin
      blk_d = blk_q - 2'd1;
    end
  end

  assign busy_o = (blk_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      blk_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      blk_q      <= blk_d;
      s1_valid_q <= accept_i;
      if (accept_i) begin
        fwd_q <= s1_valid_q && (s1_col_q == col_q);
      end
    end
  end

  // line buffer: read at accept, written back in the following cycle
  cv3_ram #(
    .WIDTH (2 * PB),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (wr_word),
    .re_i    (accept_i),
    .raddr_i (col_q),
    .rdata_o (rd_raw)
  );

  // forward a write that lands on the address read in the same cycle
  assign rd_word  = fwd_q ? fwd_data_q : rd_raw;
  assign rd_older = rd_word[2*PB-1:PB];
  assign rd_newer = rd_word[PB-1:0];
  assign wr_word  = {rd_newer, s1_pix_q};

  // stage one payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      fwd_data_q <= wr_word;
      s1_pix_q   <= pix0;
      s1_col_q   <= col_q;
      s1_rzero_q <= (row_q == '0);
      s1_rge2_q  <= (row_q >= 16'd2);
      s1_job_q   <= '{mask: mask0, row: row_q, col: cv3_pkg::OUT_COL_W'(col_q)};
    end
  end

  // new right column of the window, rows clamped at the top border
  always_comb begin
    newv[2] = s1_pix_q;
    newv[1] = s1_rzero_q ? s1_pix_q : rd_newer;
    newv[0] = s1_rzero_q ? s1_pix_q : (s1_rge2_q ? rd_older : newv[1]);
  end

  // window shift, replicated at the left border
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_valid_q) begin
      for (int i = 0; i < 3; i++) begin
        if (s1_col_q == '0) begin
          win_q[i] <= {3{newv[i]}};
        end else begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= win_q[i][2];
          win_q[i][2] <= newv[i];
        end
      end
    end
  end

  assign job_load_o = s1_valid_q;
  assign job_o      = s1_job_q;
  assign win_o      = win_q;

endmodule

`default_nettype wire

[hw/rtl/cv3_mac.sv]
// ----------------------------------------------------------------------------
// cv3_mac
// Issues the results of a job one per cycle from the window, with the row
// and column selection of each border case, then multiplies nine pixel and
// coefficient pairs, adds per kernel row and adds the three row sums.
// ----------------------------------------------------------------------------
`default_nettype none

module cv3_mac #(
  parameter int unsigned PIXEL_BITS = 16,
  parameter int unsigned COEF_BITS  = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic [2:0][cv3_pkg::KREG_W-1:0]         kern_i,
  input  wire logic                                    job_load_i,
  input  wire cv3_pkg::job_t                           job_i,
  input  wire logic [2:0][2:0][PIXEL_BITS-1:0]         win_i,
  output      logic [cv3_pkg::NRES-1:0]                mask_o,
  output      logic                                    res_valid_o,
  output      cv3_pkg::res_t                           res_o
);

  localparam int unsigned PB      = PIXEL_BITS;
  localparam int unsigned CB      = COEF_BITS;
  localparam int unsigned PROD_W  = PB + CB + 1;
  localparam int unsigned RAW_W   = PB + CB + 5;
  localparam int unsigned ACC_W   = (RAW_W > cv3_pkg::FILT_W) ? RAW_W : cv3_pkg::FILT_W;
  localparam int unsigned KX_W    = 3 * CB;

  // pending results of the current job
  logic [cv3_pkg::NRES-1:0]      mask_q, mask_d, sel_oh;
  logic [cv3_pkg::ROW_W-1:0]     jrow_q;
  logic [cv3_pkg::OUT_COL_W-1:0] jcol_q;
  logic                          issue, full_rows, full_cols;

  logic [PB-1:0]          op   [3][3];
  logic signed [CB-1:0]   coef [3][3];
  logic [2:0][KX_W-1:0]   kx;

  // product stage
  logic                          p_valid_q;
  logic signed [PROD_W-1:0]      prod_q [3][3];
  logic [cv3_pkg::ROW_W-1:0]     p_row_q;
  logic [cv3_pkg::OUT_COL_W-1:0] p_col_q;
  logic                          p_done_q;

  // row sum stage
  logic                          s_valid_q;
  logic signed [ACC_W-1:0]       rsum_q [3];
  logic [cv3_pkg::ROW_W-1:0]     s_row_q;
  logic [cv3_pkg::OUT_COL_W-1:0] s_col_q;
  logic                          s_done_q;
  logic signed [ACC_W-1:0]       total;

  // coefficients, left one in the low slot
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      kx[i] = KX_W'(kern_i[i]);
      for (int j = 0; j < 3; j++) begin
        coef[i][j] = $signed(kx[i][CB*j +: CB]);
      end
    end
  end

  // pick the earliest pending result
  always_comb begin
    sel_oh = '0;
    if (mask_q[cv3_pkg::RES_UP_MID]) begin
      sel_oh[cv3_pkg::RES_UP_MID] = 1'b1;
    end else if (mask_q[cv3_pkg::RES_UP_EDGE]) begin
      sel_oh[cv3_pkg::RES_UP_EDGE] = 1'b1;
    end else if (mask_q[cv3_pkg::RES_LAST_MID]) begin
      sel_oh[cv3_pkg::RES_LAST_MID] = 1'b1;
    end else if (mask_q[cv3_pkg::RES_LAST_EDGE]) begin
      sel_oh[cv3_pkg::RES_LAST_EDGE] = 1'b1;
    end
    issue     = (mask_q != '0);
    full_rows = sel_oh[cv3_pkg::RES_UP_MID] | sel_oh[cv3_pkg::RES_UP_EDGE];
    full_cols = sel_oh[cv3_pkg::RES_UP_MID] | sel_oh[cv3_pkg::RES_LAST_MID];
    mask_d    = job_load_i ? job_i.mask : (mask_q & ~sel_oh);
  end

  // operands: bottom row or right column replicated at the borders
  always_comb begin
    int ri;
    int cj;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ri = full_rows ? i : ((i == 0) ? 1 : 2);
        cj = full_cols ? j : ((j == 0) ? 1 : 2);
        op[i][j] = win_i[ri][cj];
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '0;
      p_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else begin
      mask_q    <= mask_d;
      p_valid_q <= issue;
      s_valid_q <= p_valid_q;
    end
  end

  // payload of the job and both arithmetic stages
  always_ff @(posedge clk_i) begin
    if (job_load_i) begin
      jrow_q <= job_i.row;
      jcol_q <= job_i.col;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_q[i][j] <= $signed({1'b0, op[i][j]}) * coef[i][j];
      end
    end
    p_row_q  <= full_rows ? jrow_q - 16'd1 : jrow_q;
    p_col_q  <= full_cols ? jcol_q - 12'd1 : jcol_q;
    p_done_q <= sel_oh[cv3_pkg::RES_LAST_EDGE];
    for (int i = 0; i < 3; i++) begin
      rsum_q[i] <= ACC_W'(prod_q[i][0]) + ACC_W'(prod_q[i][1]) + ACC_W'(prod_q[i][2]);
    end
    s_row_q  <= p_row_q;
    s_col_q  <= p_col_q;
    s_done_q <= p_done_q;
  end

  // final add goes straight into the output queue
  assign total       = rsum_q[0] + rsum_q[1] + rsum_q[2];
  assign res_valid_o = s_valid_q;
  assign res_o       = '{filtered:   $signed(total[cv3_pkg::FILT_W-1:0]),
                         out_row:    s_row_q,
                         out_col:    s_col_q,
                         frame_done: s_done_q};
  assign mask_o      = mask_q;

endmodule

`default_nettype wire

[hw/rtl/cv3_outq.sv]
// ----------------------------------------------------------------------------
// cv3_outq
// Output queue of finished results with a credit count: every accepted item
// reserves its results, so the arithmetic pipeline never has to stall.
// ----------------------------------------------------------------------------
`default_nettype none

module cv3_outq #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        reserve_i,
  input  wire logic [cv3_pkg::NRES_W-1:0]  nres_i,
  input  wire logic                        push_i,
  input  wire cv3_pkg::res_t               push_data_i,
  output      logic                        room_o,
  cv3_res_if.source                        out_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;

  cv3_pkg::res_t   fifo_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q, used_q;
  logic            pop;
  cv3_pkg::res_t   head;

  assign pop    = out_o.valid && out_o.ready;
  assign room_o = (used_q <= CW'(DEPTH - cv3_pkg::NRES));

  // pointers, fill level and reserved slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      used_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      cnt_q  <= cnt_q + CW'(push_i) - CW'(pop);
      used_q <= used_q + (reserve_i ? CW'(nres_i) : CW'(0)) - CW'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head             = fifo_q[rd_ptr_q];
  assign out_o.valid      = (cnt_q != '0);
  assign out_o.filtered   = head.filtered;
  assign out_o.out_row    = head.out_row;
  assign out_o.out_col    = head.out_col;
  assign out_o.frame_done = head.frame_done;

endmodule

`default_nettype wire

[hw/rtl/conv3x3_replicate_border.sv]
// ----------------------------------------------------------------------------
// conv3x3_replicate_border
// Streaming 3x3 correlation of a raster-order frame with a programmable
// kernel; border pixels are replicated outward on all four sides.
//
// Usage:
//   in_i carries one pixel per item in raster order; out_o carries results
//   (sum, row, column, frame-done flag) in raster order, but the last two
//   rows interleave. The result for row r-1 comes as row r arrives; on the
//   last row its own follow too, so one item can cause up to four results.
//   Configuration (width, height, three kernel rows) is written through the
//   cfg port while the block is idle; a width or height write restarts the
//   frame at row 0, column 0.
//   An accepted item passes the line-buffer read, the job register of the
//   multiply-add unit, its product and row-sum stages and the output
//   queue; further results of the same item enter the queue one per cycle.
//   Throughput: one item per cycle; an item that causes k > 1 results
//   closes the input until its hold-off counter runs out, as the multiply-add
//   unit issues one result per cycle. The line buffer is one RAM read at
//   acceptance, written back the next cycle, forwarding on a same-column hit.
//   Stall: results wait in a queue of OUTQ_DEPTH entries; input ready drops
//   when more than OUTQ_DEPTH-4 results are reserved and not yet taken.
//   Reset: counters clear, width 4096, height 1, kernel zero; the line
//   buffer is not cleared (unwritten entries are read but never used).
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_replicate_border #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned PIXEL_BITS = 16,
  parameter int unsigned COEF_BITS  = 16,
  parameter int unsigned OUTQ_DEPTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [cv3_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [cv3_pkg::CFG_W-1:0]      cfg_data_i,
  cv3_pix_if.sink                             in_i,
  cv3_res_if.source                           out_o
);

  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned WCMP_W  = (COL_W + 1 > cv3_pkg::WREG_W) ? COL_W + 1
                                                                   : cv3_pkg::WREG_W;

  // configuration registers
  logic [cv3_pkg::WREG_W-1:0]          width_q;
  logic [cv3_pkg::HREG_W-1:0]          height_q;
  logic [2:0][cv3_pkg::KREG_W-1:0]     kern_q;
  logic                                restart;
  logic [WCMP_W-1:0]                   wext;
  logic [COL_W-1:0]                    wlast;
  logic [cv3_pkg::ROW_W-1:0]           hlast;

  // datapath links
  logic                                accept;
  logic                                front_busy;
  logic [cv3_pkg::NRES_W-1:0]          nres;
  logic                                job_load;
  cv3_pkg::job_t                       job;
  logic [2:0][2:0][PIXEL_BITS-1:0]     win;
  logic [cv3_pkg::NRES-1:0]            mac_mask;
  logic                                res_valid;
  cv3_pkg::res_t                       res;
  logic                                room;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= cv3_pkg::WREG_W'(4096);
      height_q <= cv3_pkg::HREG_W'(1);
      kern_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cv3_pkg::REG_WIDTH:  width_q   <= cfg_data_i[cv3_pkg::WREG_W-1:0];
        cv3_pkg::REG_HEIGHT: height_q  <= cfg_data_i[cv3_pkg::HREG_W-1:0];
        cv3_pkg::REG_KTOP:   kern_q[0] <= cfg_data_i[cv3_pkg::KREG_W-1:0];
        cv3_pkg::REG_KMID:   kern_q[1] <= cfg_data_i[cv3_pkg::KREG_W-1:0];
        cv3_pkg::REG_KBOT:   kern_q[2] <= cfg_data_i[cv3_pkg::KREG_W-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we_i && ((cfg_idx_i == cv3_pkg::REG_WIDTH) ||
                                (cfg_idx_i == cv3_pkg::REG_HEIGHT));

  // last column and last row, zero and oversize geometry clamped
  always_comb begin
    wext = WCMP_W'(width_q);
    if (wext == '0) begin
      wlast = '0;
    end else if (wext > WCMP_W'(MAX_WIDTH)) begin
      wlast = COL_W'(MAX_WIDTH - 1);
    end else begin
      wlast = COL_W'(wext - WCMP_W'(1));
    end
    hlast = (height_q == '0) ? '0 : height_q - 16'd1;
  end

  // input handshake
  assign in_i.ready = room && !front_busy;
  assign accept     = in_i.valid && in_i.ready;

  cv3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .pixel_i    (in_i.pixel),
    .restart_i  (restart),
    .wlast_i    (wlast),
    .hlast_i    (hlast),
    .busy_o     (front_busy),
    .nres_o     (nres),
    .job_load_o (job_load),
    .job_o      (job),
    .win_o      (win)
  );

  cv3_mac #(
    .PIXEL_BITS (PIXEL_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kern_i      (kern_q),
    .job_load_i  (job_load),
    .job_i       (job),
    .win_i       (win),
    .mask_o      (mac_mask),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cv3_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .reserve_i   (accept),
    .nres_i      (nres),
    .push_i      (res_valid),
    .push_data_i (res),
    .room_o      (room),
    .out_o       (out_o)
  );

  // an item with several results closes the input on the next cycle
  a_multi_result_holdoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (nres >= 3'd2)) |=> !in_i.ready)
    else $error("input reopened while a multi-result item is issuing");

  // a new job never lands while more than one result of the old one is pending
  a_job_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_load |-> ($countones(mac_mask) <= 1))
    else $error("window job overwritten before its results were issued");

  // a result entering the queue is visible on the output next cycle
  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> out_o.valid)
    else $error("queued result not presented");

endmodule

`default_nettype wire
